/* rtl/hlt_pkg.sv */
// Shared types and constants for the hex line trace block.
// No dependencies; imported by every module of the block.
package hlt_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int MAX_RANGE_DEF  = 63;
  localparam int STEP_BITS      = 6;
  localparam int SYS_BITS       = 2;

  typedef logic [SYS_BITS-1:0] sys_t;
  localparam sys_t SYS_OFFSET = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIST,
    ST_PREP,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic measure;
    logic prep;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_sts_t;

endpackage

/* rtl/hex_line_trace_unit.sv */
// Top level of the hex line trace: traces a line between two hexes and
// emits every hex on it in even-r offset coordinates.
// Depends on hlt_pkg, hlt_ctrl and hlt_datapath.
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  in_      | request   | tdata: origin_a, origin_b, target_a, target_b
//  out_     | result    | tdata: hex_col, hex_row, step_number; tlast; tuser
//  cfg_     | write     | wr_data: input_system
//
// A request passes the setup steps, then one hex per cycle follows while
// the output does not stall; a line that is empty or too long gives one hex.
// The setup steps are axial conversion, distance, and step remainders.
// Reset is synchronous; input_system returns to axial.
// Output stalls hold the stepping loop; a new request is taken once the
// last hex of the line sits in the output register.
module hex_line_trace_unit #(
  parameter int COORD_BITS = hlt_pkg::COORD_BITS_DEF,
  parameter int MAX_RANGE  = hlt_pkg::MAX_RANGE_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_wr_en,
  input  logic [hlt_pkg::SYS_BITS-1:0]             cfg_wr_data,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // origin_a, origin_b, target_a, target_b
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]        in_tdata,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // hex_col, hex_row, step_number, zero fill
  output logic [((2*COORD_BITS+hlt_pkg::STEP_BITS+8)/8)*8-1:0] out_tdata,
  output logic                                     out_tlast,
  // too_long
  output logic                                     out_tuser
);
  import hlt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  hlt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  hlt_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_RANGE  (MAX_RANGE)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule

/* rtl/hlt_datapath.sv */
// Datapath of the hex line trace: coordinate conversion, distance, per-step
// fraction tracking, cube rounding and the result register.
// Depends on hlt_pkg; driven by hlt_ctrl through dp_cmd_t.
module hlt_datapath #(
  parameter int COORD_BITS = hlt_pkg::COORD_BITS_DEF,
  parameter int MAX_RANGE  = hlt_pkg::MAX_RANGE_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_wr_en,
  input  logic [hlt_pkg::SYS_BITS-1:0]             cfg_wr_data,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]        in_tdata,
  input  hlt_pkg::dp_cmd_t                         cmd,
  output hlt_pkg::dp_sts_t                         sts,
  output logic [((2*COORD_BITS+hlt_pkg::STEP_BITS+8)/8)*8-1:0] out_tdata,
  output logic                                     out_tlast,
  output logic                                     out_tuser
);
  import hlt_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int W     = CB + 3;
  localparam int SUMW  = CB + 4;
  localparam int NW    = CB + 2;
  localparam int SB    = STEP_BITS;
  localparam int RW    = SB + 1;
  localparam int OUT_W = ((2*CB+SB+8)/8)*8;
  localparam int PAD_W = OUT_W - (2*CB + SB + 1);

  function automatic logic signed [W-1:0] sx(input logic [CB-1:0] v);
    sx = {{(W-CB){v[CB-1]}}, v};
  endfunction

  function automatic logic signed [W-1:0] half_even(input logic signed [W-1:0] v);
    half_even = $signed(v + {{(W-1){1'b0}}, v[0]}) >>> 1;
  endfunction

  function automatic logic [W-1:0] absw(input logic signed [W-1:0] v);
    absw = v[W-1] ? -v : v;
  endfunction

  sys_t                  sys_r;
  logic signed [W-1:0]   q0_r, r0_r, q1_r, r1_r;
  logic signed [W-1:0]   d_r   [3];
  logic signed [W-1:0]   b_r   [3];
  logic [SB-1:0]         rem_r [3];
  logic [SB-1:0]         rr_r  [3];
  logic [2:0]            up_r, dn_r;
  logic [SB-1:0]         n_r;
  logic [SB-1:0]         step_r;
  logic                  single_r, long_r;
  logic [CB:0]           col_r;
  logic [CB-1:0]         row_r;
  logic [SB-1:0]         ostep_r;
  logic                  olast_r, olong_r;

  logic signed [W-1:0]   a0, b0, a1, b1;
  logic signed [W-1:0]   dq, dr, ds;
  logic [SUMW-1:0]       dsum;
  logic [NW-1:0]         n_full;
  logic signed [W-1:0]   k     [3];
  logic [SB-1:0]         err   [3];
  logic signed [W-1:0]   b_nxt [3];
  logic [SB-1:0]         rem_nxt [3];
  logic [SB-1:0]         rr_nxt  [3];
  logic [2:0]            up_nxt, dn_nxt;
  logic signed [W-1:0]   hx, hz, col_w;
  logic                  last;

  assign a0 = sx(in_tdata[CB-1:0]);
  assign b0 = sx(in_tdata[2*CB-1:CB]);
  assign a1 = sx(in_tdata[3*CB-1:2*CB]);
  assign b1 = sx(in_tdata[4*CB-1:3*CB]);

  assign dq     = q1_r - q0_r;
  assign dr     = r1_r - r0_r;
  assign ds     = -dq - dr;
  assign dsum   = SUMW'(absw(dq)) + SUMW'(absw(dr)) + SUMW'(absw(ds));
  assign n_full = dsum[NW:1];

  always_comb begin
    logic [RW-1:0] twice;
    logic [RW-1:0] rs;
    logic          carry;
    for (int c = 0; c < 3; c++) begin
      twice = {rem_r[c], 1'b0};
      if (b_r[c][W-1]) begin
        k[c] = b_r[c] + W'(twice > {1'b0, n_r});
      end else begin
        k[c] = b_r[c] + W'(twice >= {1'b0, n_r});
      end
      err[c] = (k[c] != b_r[c]) ? (n_r - rem_r[c]) : rem_r[c];

      rs         = {1'b0, rem_r[c]} + {1'b0, rr_r[c]};
      carry      = rs >= {1'b0, n_r};
      rem_nxt[c] = carry ? SB'(rs - {1'b0, n_r}) : rs[SB-1:0];
      b_nxt[c]   = b_r[c] + {{(W-1){1'b0}}, up_r[c]} + {{(W-1){1'b0}}, carry}
                   - {{(W-1){1'b0}}, dn_r[c]};

      up_nxt[c] = d_r[c] == $signed({{(W-SB){1'b0}}, n_r});
      dn_nxt[c] = d_r[c][W-1];
      if (dn_nxt[c]) begin
        rr_nxt[c] = SB'(d_r[c] + $signed({{(W-SB){1'b0}}, n_r}));
      end else if (up_nxt[c]) begin
        rr_nxt[c] = '0;
      end else begin
        rr_nxt[c] = d_r[c][SB-1:0];
      end
    end
  end

  always_comb begin
    hx = k[0];
    hz = k[2];
    if (err[0] > err[1] && err[0] > err[2]) begin
      hx = -k[1] - k[2];
    end else if (err[1] > err[2]) begin
      hx = k[0];
    end else begin
      hz = -k[0] - k[1];
    end
    if (single_r) begin
      hx = q0_r;
      hz = r0_r;
    end
    col_w = hx + half_even(hz);
  end

  assign last     = single_r || (step_r == n_r);
  assign sts.last = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_r <= '0;
    end else if (cfg_wr_en) begin
      sys_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q0_r <= (sys_r == SYS_OFFSET) ? a0 - half_even(b0) : a0;
      r0_r <= b0;
      q1_r <= (sys_r == SYS_OFFSET) ? a1 - half_even(b1) : a1;
      r1_r <= b1;
    end
    if (cmd.measure) begin
      d_r[0]   <= dq;
      d_r[1]   <= ds;
      d_r[2]   <= dr;
      long_r   <= n_full > NW'(MAX_RANGE);
      single_r <= (n_full > NW'(MAX_RANGE)) || (n_full == '0);
      n_r      <= n_full[SB-1:0];
    end
    if (cmd.prep) begin
      b_r[0] <= q0_r;
      b_r[1] <= -q0_r - r0_r;
      b_r[2] <= r0_r;
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= '0;
        rr_r[c]  <= rr_nxt[c];
      end
      up_r   <= up_nxt;
      dn_r   <= dn_nxt;
      step_r <= '0;
    end
    if (cmd.step) begin
      col_r   <= col_w[CB:0];
      row_r   <= hz[CB-1:0];
      ostep_r <= step_r;
      olast_r <= last;
      olong_r <= long_r;
      for (int c = 0; c < 3; c++) begin
        b_r[c]   <= b_nxt[c];
        rem_r[c] <= rem_nxt[c];
      end
      step_r <= step_r + SB'(1);
    end
  end

  assign out_tdata = {{PAD_W{1'b0}}, ostep_r, row_r, col_r};
  assign out_tlast = olast_r;
  assign out_tuser = olong_r;

  a_rem_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && !single_r |-> rem_r[0] < n_r && rem_r[1] < n_r && rem_r[2] < n_r)
    else $error("fraction remainder out of range");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && !single_r |-> step_r <= n_r)
    else $error("step counter ran past line length");

endmodule

/* rtl/hlt_ctrl.sv */
// Controller of the hex line trace: request sequencing and result valid.
// Depends on hlt_pkg; commands hlt_datapath through dp_cmd_t.
module hlt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output hlt_pkg::dp_cmd_t cmd,
  input  hlt_pkg::dp_sts_t sts
);
  import hlt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIST;
        end
      end
      ST_DIST: begin
        cmd.measure = 1'b1;
        state_nxt   = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (!out_valid_r || out_tready) begin
          cmd.step = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> out_tvalid)
    else $error("emitted hex not presented");

  a_no_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmd.step)
    else $error("hex emitted while taking requests");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && sts.last |=> in_tready)
    else $error("not ready after last hex of line");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for hex_line_trace_unit: sends line requests, predicts every
// hex on each line and compares it with the result stream.
// Depends on hlt_pkg and the hex_line_trace_unit RTL.
module tb_top;
  import hlt_pkg::*;

  localparam sys_t SYS_AXIAL = 2'd0;
  localparam sys_t SYS_CUBE  = 2'd1;
  localparam sys_t SYS_SPARE = 2'd3;
  localparam int   COORD_MIN = -2048;
  localparam int   COORD_MAX = 2047;
  localparam int   LINE_MAX  = 63;
  localparam int   HOLD_CYCLES = 300;

  typedef struct {
    logic [12:0] col;
    logic [11:0] row;
    logic [5:0]  step;
    logic        fin;
    logic        lng;
  } hex_rec_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  // origin_a, origin_b, target_a, target_b
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // hex_col, hex_row, step_number, zero fill
  logic [31:0] out_tdata;
  logic        out_tlast;
  // too_long
  logic        out_tuser;

  hex_line_trace_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  hex_rec_t pending_hexes[$];
  sys_t     line_sys;
  int       send_idle_pct = 14;
  int       recv_idle_pct = 72;
  int       fail_count = 0;
  logic     recv_hold = 1'b0;
  event     recv_hold_ev;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------- prediction ----------------
  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint half_even(longint row);
    return (row + (row & 1)) / 2;
  endfunction

  function automatic longint round_half_away(longint num, longint den, output longint err);
    longint k;
    longint res;
    k   = (2 * mag(num) + den) / (2 * den);
    res = (num < 0) ? -k : k;
    err = mag(res * den - num);
    return res;
  endfunction

  function automatic void push_hex(longint q, longint r, int step, bit fin, bit lng);
    hex_rec_t rec;
    longint   col;
    col      = q + half_even(r);
    rec.col  = col[12:0];
    rec.row  = r[11:0];
    rec.step = step[5:0];
    rec.fin  = fin;
    rec.lng  = lng;
    pending_hexes.push_back(rec);
  endfunction

  function automatic void trace_hexes(int a0, int b0, int a1, int b1);
    longint q0, r0, q1, r1, dq, dr, n;
    longint nx, nz, ny, x, y, z, ex, ey, ez;
    q0 = a0;
    r0 = b0;
    q1 = a1;
    r1 = b1;
    if (line_sys == SYS_OFFSET) begin
      q0 = a0 - half_even(b0);
      q1 = a1 - half_even(b1);
    end
    dq = q1 - q0;
    dr = r1 - r0;
    n  = (mag(dq) + mag(dr) + mag(dq + dr)) / 2;
    if (n > LINE_MAX) begin
      push_hex(q0, r0, 0, 1'b1, 1'b1);
    end else if (n == 0) begin
      push_hex(q0, r0, 0, 1'b1, 1'b0);
    end else begin
      for (int i = 0; i <= n; i++) begin
        nx = q0 * n + dq * i;
        nz = r0 * n + dr * i;
        ny = -nx - nz;
        x  = round_half_away(nx, n, ex);
        y  = round_half_away(ny, n, ey);
        z  = round_half_away(nz, n, ez);
        if (ex > ey && ex > ez) begin
          x = -y - z;
        end else if (ey > ez) begin
          y = -x - z;
        end else begin
          z = -x - y;
        end
        push_hex(x, z, i, i == n, 1'b0);
      end
    end
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    forever begin
      @(recv_hold_ev);
      recv_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      recv_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    hex_rec_t exp_hex;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hexes.size() == 0) begin
        $error("unexpected result: hex_col %0d hex_row %0d", $signed(out_tdata[12:0]),
               $signed(out_tdata[24:13]));
        fail_count++;
      end else begin
        exp_hex = pending_hexes.pop_front();
        if (out_tdata[12:0] !== exp_hex.col) begin
          $error("hex_col expected %0d actual %0d", $signed(exp_hex.col),
                 $signed(out_tdata[12:0]));
          fail_count++;
        end
        if (out_tdata[24:13] !== exp_hex.row) begin
          $error("hex_row expected %0d actual %0d", $signed(exp_hex.row),
                 $signed(out_tdata[24:13]));
          fail_count++;
        end
        if (out_tdata[30:25] !== exp_hex.step) begin
          $error("step_number expected %0d actual %0d", exp_hex.step, out_tdata[30:25]);
          fail_count++;
        end
        if (out_tlast !== exp_hex.fin) begin
          $error("final_hex expected %0d actual %0d", exp_hex.fin, out_tlast);
          fail_count++;
        end
        if (out_tuser !== exp_hex.lng) begin
          $error("too_long expected %0d actual %0d", exp_hex.lng, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // ---------------- request side ----------------
  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic send_line(input int a0, input int b0, input int a1, input int b1);
    trace_hexes(a0, b0, a1, b1);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b1[11:0], a1[11:0], b0[11:0], a0[11:0]};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_hexes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_input_system(input sys_t sys);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sys;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    line_sys = sys;
  endtask

  task automatic send_random_line(input int span_max);
    int pick, span, da, db;
    int a0, b0, a1, b1;
    pick = $urandom_range(99);
    a0   = rand_between(COORD_MIN, COORD_MAX);
    b0   = rand_between(COORD_MIN, COORD_MAX);
    if (pick < 80) begin
      span = ($urandom_range(9) == 0) ? span_max : 6;
      da   = rand_between(-span, span);
      db   = rand_between(-span, span);
      a1   = a0 + da;
      b1   = b0 + db;
      if (a1 > COORD_MAX || a1 < COORD_MIN) a1 = a0 - da;
      if (b1 > COORD_MAX || b1 < COORD_MIN) b1 = b0 - db;
    end else if (pick < 92) begin
      a1 = rand_between(COORD_MIN, COORD_MAX);
      b1 = rand_between(COORD_MIN, COORD_MAX);
    end else begin
      a1 = a0;
      b1 = b0;
    end
    send_line(a0, b0, a1, b1);
  endtask

  // ---------------- tests ----------------
  task automatic test_axial_lines();
    send_line(0, 0, 0, 0);
    send_line(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_line(0, 0, 63, 0);
    send_line(0, 0, 64, 0);
    send_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_line(0, 0, 1, 1);
    send_line(-3, -2, 4, -7);
    set_input_system(SYS_AXIAL);
    send_line(5, -5, -5, 5);
    send_line(0, 0, 31, -63);
  endtask

  task automatic test_cube_lines();
    set_input_system(SYS_CUBE);
    send_line(COORD_MAX, COORD_MIN, 2040, -2030);
    send_line(-1, -1, 3, 2);
    send_line(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
  endtask

  task automatic test_offset_lines();
    set_input_system(SYS_OFFSET);
    send_line(5, -3, -2, 4);
    send_line(COORD_MIN, COORD_MAX, -2040, 2020);
    send_line(COORD_MAX, -2047, COORD_MAX, -2047);
    send_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_line(0, 1, 0, 62);
  endtask

  task automatic test_spare_selector();
    set_input_system(SYS_SPARE);
    send_line(0, 0, 7, -3);
    send_line(-1, 2, -1, 2);
  endtask

  task automatic test_output_backpressure();
    set_input_system(SYS_AXIAL);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    -> recv_hold_ev;
    repeat (12) send_random_line(6);
    wait_drained();
  endtask

  task automatic run_random_phase(input int count, input int s_pct, input int r_pct,
                                  input sys_t sys);
    set_input_system(sys);
    send_idle_pct = s_pct;
    recv_idle_pct <= r_pct;
    repeat (count) send_random_line(31);
  endtask

  task automatic test_random_lines();
    run_random_phase(100, 14, 72, SYS_OFFSET);
    run_random_phase(100, 72, 14, SYS_AXIAL);
    run_random_phase(44, 0, 0, SYS_SPARE);
    run_random_phase(44, 0, 0, SYS_CUBE);
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = SYS_AXIAL;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    line_sys    = SYS_AXIAL;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_axial_lines();
    test_cube_lines();
    test_offset_lines();
    test_spare_selector();
    test_output_backpressure();
    test_random_lines();
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hlt_pkg.sv
rtl/hlt_datapath.sv
rtl/hlt_ctrl.sv
rtl/hex_line_trace_unit.sv
sim/tb_top.sv
